// File: src/zmachine_table_memory_ops_core_macros.svh
// ----------------------------------------------------------------------------
// zmachine_table_memory_ops_core assertion macros
// Concurrent assertion helpers, clocked on i_clk, disabled while i_rst_n low.
// ----------------------------------------------------------------------------
`ifndef ZMACHINE_TABLE_MEMORY_OPS_CORE_MACROS_SVH
`define ZMACHINE_TABLE_MEMORY_OPS_CORE_MACROS_SVH

// same-cycle implication
`define ZMTM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ZMTM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/zmtm_pkg.sv
// ----------------------------------------------------------------------------
// zmtm_pkg
// Shared constants, types and the control store of the table-opcode unit.
// ----------------------------------------------------------------------------
package zmtm_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam logic [16:0] ADDR_LIMIT = 17'(MEM_BYTES);

    localparam logic [7:0] FORM_DEFAULT = 8'h82;

    localparam logic [2:0] CMD_LOADB  = 3'd0;
    localparam logic [2:0] CMD_LOADW  = 3'd1;
    localparam logic [2:0] CMD_STOREB = 3'd2;
    localparam logic [2:0] CMD_STOREW = 3'd3;
    localparam logic [2:0] CMD_COPY   = 3'd4;
    localparam logic [2:0] CMD_SCAN   = 3'd5;

    localparam int PC_W = 5;

    localparam logic [PC_W-1:0] PC_LB0  = 5'd0;
    localparam logic [PC_W-1:0] PC_LB1  = 5'd1;
    localparam logic [PC_W-1:0] PC_LW0  = 5'd2;
    localparam logic [PC_W-1:0] PC_LW1  = 5'd3;
    localparam logic [PC_W-1:0] PC_LW2  = 5'd4;
    localparam logic [PC_W-1:0] PC_SB0  = 5'd5;
    localparam logic [PC_W-1:0] PC_SW0  = 5'd6;
    localparam logic [PC_W-1:0] PC_SW1  = 5'd7;
    localparam logic [PC_W-1:0] PC_FL0  = 5'd8;
    localparam logic [PC_W-1:0] PC_FL1  = 5'd9;
    localparam logic [PC_W-1:0] PC_FW0  = 5'd10;
    localparam logic [PC_W-1:0] PC_FW1  = 5'd11;
    localparam logic [PC_W-1:0] PC_FW2  = 5'd12;
    localparam logic [PC_W-1:0] PC_BW0  = 5'd13;
    localparam logic [PC_W-1:0] PC_BW1  = 5'd14;
    localparam logic [PC_W-1:0] PC_BW2  = 5'd15;
    localparam logic [PC_W-1:0] PC_DONE = 5'd16;
    localparam logic [PC_W-1:0] PC_SC0  = 5'd17;
    localparam logic [PC_W-1:0] PC_SC1  = 5'd18;
    localparam logic [PC_W-1:0] PC_SCB  = 5'd19;
    localparam logic [PC_W-1:0] PC_SCS  = 5'd20;
    localparam logic [PC_W-1:0] PC_SCW0 = 5'd21;
    localparam logic [PC_W-1:0] PC_SCW1 = 5'd22;
    localparam logic [PC_W-1:0] PC_SCWS = 5'd23;
    localparam logic [PC_W-1:0] PC_FND  = 5'd24;
    localparam logic [PC_W-1:0] PC_LAST = PC_FND;

    // memory operation
    localparam logic [1:0] MEM_NONE = 2'd0;
    localparam logic [1:0] MEM_RD   = 2'd1;
    localparam logic [1:0] MEM_WR   = 2'd2;

    // address select
    localparam logic [1:0] A_SRC  = 2'd0;
    localparam logic [1:0] A_SRC1 = 2'd1;
    localparam logic [1:0] A_DST  = 2'd2;

    // write data select
    localparam logic [1:0] W_ZERO  = 2'd0;
    localparam logic [1:0] W_CHI   = 2'd1;
    localparam logic [1:0] W_CLO   = 2'd2;
    localparam logic [1:0] W_RDATA = 2'd3;

    // pointer moves
    localparam logic [2:0] MV_NONE     = 3'd0;
    localparam logic [2:0] MV_SRC_STEP = 3'd1;
    localparam logic [2:0] MV_BOTH_INC = 3'd2;
    localparam logic [2:0] MV_BOTH_DEC = 3'd3;
    localparam logic [2:0] MV_DST_INC  = 3'd4;

    // result value updates
    localparam logic [2:0] V_HOLD = 3'd0;
    localparam logic [2:0] V_LO   = 3'd1;
    localparam logic [2:0] V_HI   = 3'd2;
    localparam logic [2:0] V_ORLO = 3'd3;
    localparam logic [2:0] V_ADDR = 3'd4;

    // jump conditions
    localparam logic [2:0] C_NEXT   = 3'd0;
    localparam logic [2:0] C_ALWAYS = 3'd1;
    localparam logic [2:0] C_CNTZ   = 3'd2;
    localparam logic [2:0] C_WORDS  = 3'd3;
    localparam logic [2:0] C_MATCHB = 3'd4;
    localparam logic [2:0] C_MATCHW = 3'd5;

    typedef struct packed {
        logic [1:0]      mem_op;
        logic [1:0]      asel;
        logic [1:0]      wsel;
        logic [2:0]      mv;
        logic            cnt_dec;
        logic [2:0]      vop;
        logic            hi_ld;
        logic            br_set;
        logic            done;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic        we;
        logic        re;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

    function automatic t_uword uw(
        logic [1:0] mem, logic [1:0] asel, logic [1:0] wsel, logic [2:0] mv,
        logic dec, logic [2:0] vop, logic hi, logic br, logic done,
        logic [2:0] cond, logic [PC_W-1:0] target
    );
        t_uword w;
        w.mem_op  = mem;
        w.asel    = asel;
        w.wsel    = wsel;
        w.mv      = mv;
        w.cnt_dec = dec;
        w.vop     = vop;
        w.hi_ld   = hi;
        w.br_set  = br;
        w.done    = done;
        w.cond    = cond;
        w.target  = target;
        return w;
    endfunction

    function automatic t_uword ucode_rom(logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            PC_LB0:  w = uw(MEM_RD, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_NEXT, PC_LB0);
            PC_LB1:  w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_LO, 0, 0, 1, C_NEXT, PC_LB0);
            PC_LW0:  w = uw(MEM_RD, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_NEXT, PC_LB0);
            PC_LW1:  w = uw(MEM_RD, A_SRC1, W_ZERO, MV_NONE, 0, V_HI, 0, 0, 0, C_NEXT, PC_LB0);
            PC_LW2:  w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_ORLO, 0, 0, 1, C_NEXT, PC_LB0);
            PC_SB0:  w = uw(MEM_WR, A_SRC, W_CLO, MV_NONE, 0, V_HOLD, 0, 0, 1, C_NEXT, PC_LB0);
            PC_SW0:  w = uw(MEM_WR, A_SRC, W_CHI, MV_NONE, 0, V_HOLD, 0, 0, 0, C_NEXT, PC_LB0);
            PC_SW1:  w = uw(MEM_WR, A_SRC1, W_CLO, MV_NONE, 0, V_HOLD, 0, 0, 1, C_NEXT, PC_LB0);
            PC_FL0:  w = uw(MEM_NONE, A_DST, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_CNTZ, PC_DONE);
            PC_FL1:  w = uw(MEM_WR, A_DST, W_ZERO, MV_DST_INC, 1, V_HOLD, 0, 0, 0, C_ALWAYS,
                            PC_FL0);
            PC_FW0:  w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_CNTZ, PC_DONE);
            PC_FW1:  w = uw(MEM_RD, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_NEXT, PC_LB0);
            PC_FW2:  w = uw(MEM_WR, A_DST, W_RDATA, MV_BOTH_INC, 1, V_HOLD, 0, 0, 0, C_ALWAYS,
                            PC_FW0);
            PC_BW0:  w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_CNTZ, PC_DONE);
            PC_BW1:  w = uw(MEM_RD, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_NEXT, PC_LB0);
            PC_BW2:  w = uw(MEM_WR, A_DST, W_RDATA, MV_BOTH_DEC, 1, V_HOLD, 0, 0, 0, C_ALWAYS,
                            PC_BW0);
            PC_DONE: w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 1, C_NEXT, PC_LB0);
            PC_SC0:  w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_CNTZ, PC_DONE);
            PC_SC1:  w = uw(MEM_RD, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_WORDS, PC_SCW0);
            PC_SCB:  w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_MATCHB, PC_FND);
            PC_SCS:  w = uw(MEM_NONE, A_SRC, W_ZERO, MV_SRC_STEP, 1, V_HOLD, 0, 0, 0, C_ALWAYS,
                            PC_SC0);
            PC_SCW0: w = uw(MEM_RD, A_SRC1, W_ZERO, MV_NONE, 0, V_HOLD, 1, 0, 0, C_NEXT, PC_LB0);
            PC_SCW1: w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 0, C_MATCHW, PC_FND);
            PC_SCWS: w = uw(MEM_NONE, A_SRC, W_ZERO, MV_SRC_STEP, 1, V_HOLD, 0, 0, 0, C_ALWAYS,
                            PC_SC0);
            PC_FND:  w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_ADDR, 0, 1, 1, C_NEXT, PC_LB0);
            default: w = uw(MEM_NONE, A_SRC, W_ZERO, MV_NONE, 0, V_HOLD, 0, 0, 1, C_NEXT, PC_LB0);
        endcase
        return w;
    endfunction

endpackage

// File: src/zmtm_mem.sv
// ----------------------------------------------------------------------------
// zmtm_mem
// Story byte memory: one access per cycle, registered read data, addresses
// at or beyond the memory size read as zero and ignore writes.
// ----------------------------------------------------------------------------
module zmtm_mem (
    input  logic               i_clk,
    input  zmtm_pkg::t_mem_req i_req,
    output logic [7:0]         o_rdata
);
    import zmtm_pkg::*;

    logic [7:0]        r_mem [MEM_BYTES];
    logic [7:0]        r_rd;
    logic              r_oor;
    logic              w_in_range;
    logic [MEM_AW-1:0] w_idx;

    assign w_in_range = {1'b0, i_req.addr} < ADDR_LIMIT;
    assign w_idx      = i_req.addr[MEM_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.we && w_in_range) begin
            r_mem[w_idx] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd  <= r_mem[w_idx];
            r_oor <= !w_in_range;
        end
    end

    assign o_rdata = r_oor ? 8'h00 : r_rd;

endmodule

// File: src/zmachine_table_memory_ops_core.sv
// ----------------------------------------------------------------------------
// zmachine_table_memory_ops_core
// Table opcodes (load/store byte and word, copy_table, scan_table) over a
// byte memory, run by a microcoded sequencer.
//
// After reset the unit sweeps all MEM_BYTES bytes of the memory (65536 by
// default) to zero, one byte per cycle, and stalls its input until done.
// One word is processed at a time; all timing comes from the single byte
// port of the memory with its registered read. Copy fills with zeros when
// the second operand is zero and otherwise copies forwards or backwards
// byte by byte; scan steps through byte or word tables and stops at the
// first entry that matches. A finished result that finds the output
// register still held by a stalled word waits in the last step until the
// register frees. A new word is accepted the cycle after the previous one
// finishes, while its result may still wait in the output register.
// ----------------------------------------------------------------------------
`include "zmachine_table_memory_ops_core_macros.svh"

module zmachine_table_memory_ops_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_arg_a,
    input  logic [15:0] i_arg_b,
    input  logic [15:0] i_arg_c,
    input  logic [7:0]  i_scan_form,
    input  logic        i_form_given,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_result_value,
    output logic        o_has_value,
    output logic        o_branch_taken
);
    import zmtm_pkg::*;

    logic              r_clearing, n_clearing;
    logic [MEM_AW-1:0] r_clr_addr, n_clr_addr;
    logic              r_busy, n_busy;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic              r_ovalid, n_ovalid;

    logic [15:0] r_a, n_a;
    logic [15:0] r_c, n_c;
    logic [7:0]  r_form, n_form;
    logic [15:0] r_src, n_src;
    logic [15:0] r_dst, n_dst;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] r_val, n_val;
    logic [7:0]  r_hi, n_hi;
    logic        r_hv, n_hv;
    logic        r_br, n_br;
    logic [15:0] r_oval, n_oval;
    logic        r_ohv, n_ohv;
    logic        r_obr, n_obr;

    t_uword      w_uw;
    t_mem_req    w_req;
    logic [7:0]  w_rdata;
    logic        w_accept;
    logic        w_hold;
    logic        w_step;
    logic        w_cond;
    logic [15:0] w_src_inc;

    zmtm_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    assign o_in_stall = r_clearing || r_busy;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_uw       = ucode_rom(r_pc);
    assign w_hold     = w_uw.done && r_ovalid && i_out_stall;
    assign w_step     = r_busy && !w_hold;
    assign w_src_inc  = r_src + 16'd1;

    always_comb begin
        unique case (w_uw.cond)
            C_NEXT:   w_cond = 1'b0;
            C_ALWAYS: w_cond = 1'b1;
            C_CNTZ:   w_cond = r_cnt == 16'd0;
            C_WORDS:  w_cond = r_form[7];
            C_MATCHB: w_cond = r_a == {8'h00, w_rdata};
            C_MATCHW: w_cond = r_a == {r_hi, w_rdata};
            default:  w_cond = 1'b0;
        endcase
    end

    always_comb begin
        w_req = '0;
        if (r_clearing) begin
            w_req.we   = 1'b1;
            w_req.addr = 16'(r_clr_addr);
        end else begin
            w_req.we = w_step && (w_uw.mem_op == MEM_WR);
            w_req.re = w_step && (w_uw.mem_op == MEM_RD);
            unique case (w_uw.asel)
                A_SRC:   w_req.addr = r_src;
                A_SRC1:  w_req.addr = w_src_inc;
                A_DST:   w_req.addr = r_dst;
                default: w_req.addr = r_src;
            endcase
            unique case (w_uw.wsel)
                W_ZERO:  w_req.wdata = 8'h00;
                W_CHI:   w_req.wdata = r_c[15:8];
                W_CLO:   w_req.wdata = r_c[7:0];
                W_RDATA: w_req.wdata = w_rdata;
                default: w_req.wdata = 8'h00;
            endcase
        end
    end

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        n_busy     = r_busy;
        n_pc       = r_pc;
        n_ovalid   = r_ovalid;
        n_a        = r_a;
        n_c        = r_c;
        n_form     = r_form;
        n_src      = r_src;
        n_dst      = r_dst;
        n_cnt      = r_cnt;
        n_val      = r_val;
        n_hi       = r_hi;
        n_hv       = r_hv;
        n_br       = r_br;
        n_oval     = r_oval;
        n_ohv      = r_ohv;
        n_obr      = r_obr;

        if (r_clearing) begin
            n_clr_addr = r_clr_addr + MEM_AW'(1);
            if (r_clr_addr == MEM_AW'(MEM_BYTES - 1)) begin
                n_clearing = 1'b0;
            end
        end

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        if (w_accept) begin
            n_busy = 1'b1;
            n_a    = i_arg_a;
            n_c    = i_arg_c;
            n_form = i_form_given ? i_scan_form : FORM_DEFAULT;
            n_cnt  = i_arg_c;
            n_val  = 16'd0;
            n_br   = 1'b0;
            n_hv   = (i_cmd == CMD_LOADB) || (i_cmd == CMD_LOADW) || (i_cmd == CMD_SCAN);
            n_src  = i_arg_a + i_arg_b;
            n_dst  = i_arg_b;
            unique case (i_cmd)
                CMD_LOADB:  n_pc = PC_LB0;
                CMD_LOADW: begin
                    n_src = i_arg_a + {i_arg_b[14:0], 1'b0};
                    n_pc  = PC_LW0;
                end
                CMD_STOREB: n_pc = PC_SB0;
                CMD_STOREW: begin
                    n_src = i_arg_a + {i_arg_b[14:0], 1'b0};
                    n_pc  = PC_SW0;
                end
                CMD_COPY: begin
                    if (i_arg_b == 16'd0) begin
                        n_dst = i_arg_a;
                        n_pc  = PC_FL0;
                    end else if (i_arg_c[15] || (i_arg_a > i_arg_b)) begin
                        n_src = i_arg_a;
                        n_cnt = i_arg_c[15] ? (~i_arg_c + 16'd1) : i_arg_c;
                        n_pc  = PC_FW0;
                    end else begin
                        n_src = i_arg_a + i_arg_c - 16'd1;
                        n_dst = i_arg_b + i_arg_c - 16'd1;
                        n_pc  = PC_BW0;
                    end
                end
                CMD_SCAN: begin
                    n_src = i_arg_b;
                    n_pc  = PC_SC0;
                end
                default:    n_pc = PC_DONE;
            endcase
        end else if (w_step) begin
            n_pc = w_cond ? w_uw.target : r_pc + PC_W'(1);
            unique case (w_uw.mv)
                MV_NONE: ;
                MV_SRC_STEP: n_src = r_src + {9'd0, r_form[6:0]};
                MV_BOTH_INC: begin
                    n_src = w_src_inc;
                    n_dst = r_dst + 16'd1;
                end
                MV_BOTH_DEC: begin
                    n_src = r_src - 16'd1;
                    n_dst = r_dst - 16'd1;
                end
                MV_DST_INC:  n_dst = r_dst + 16'd1;
                default: ;
            endcase
            if (w_uw.cnt_dec) begin
                n_cnt = r_cnt - 16'd1;
            end
            if (w_uw.hi_ld) begin
                n_hi = w_rdata;
            end
            unique case (w_uw.vop)
                V_HOLD: ;
                V_LO:    n_val = {8'h00, w_rdata};
                V_HI:    n_val = {w_rdata, 8'h00};
                V_ORLO:  n_val = {r_val[15:8], w_rdata};
                V_ADDR:  n_val = r_src;
                default: ;
            endcase
            if (w_uw.br_set) begin
                n_br = 1'b1;
            end
            if (w_uw.done) begin
                n_busy   = 1'b0;
                n_ovalid = 1'b1;
                n_oval   = n_val;
                n_ohv    = r_hv;
                n_obr    = n_br;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_busy     <= 1'b0;
            r_pc       <= PC_DONE;
            r_ovalid   <= 1'b0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
            r_busy     <= n_busy;
            r_pc       <= n_pc;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_c    <= n_c;
        r_form <= n_form;
        r_src  <= n_src;
        r_dst  <= n_dst;
        r_cnt  <= n_cnt;
        r_val  <= n_val;
        r_hi   <= n_hi;
        r_hv   <= n_hv;
        r_br   <= n_br;
        r_oval <= n_oval;
        r_ohv  <= n_ohv;
        r_obr  <= n_obr;
    end

    assign o_out_valid    = r_ovalid;
    assign o_result_value = r_oval;
    assign o_has_value    = r_ohv;
    assign o_branch_taken = r_obr;

    `ZMTM_ASSERT_NEXT(a_accept_starts, w_accept, r_busy, "accepted word did not start")
    `ZMTM_ASSERT_NOW(a_clear_quiet, r_clearing, !r_busy && !r_ovalid, "activity during clear")
    `ZMTM_ASSERT_NEXT(a_done_posts, w_step && w_uw.done, r_ovalid && !r_busy, "result lost")
    `ZMTM_ASSERT_NOW(a_idle_no_access, !r_busy && !r_clearing, !w_req.we && !w_req.re,
                     "idle access")
    `ZMTM_ASSERT_NOW(a_pc_range, r_busy, r_pc <= PC_LAST, "sequencer out of program")

endmodule
